/* hdl/bcpsm_pkg.sv */
// ----------------------------------------------------------------------------
// bcpsm_pkg
// Shared constants and types for the binary curve point scalar multiplier.
// ----------------------------------------------------------------------------
package bcpsm_pkg;

	localparam int FIELD_BITS_DEF  = 31;
	localparam int SCALAR_BITS_DEF = 32;
	localparam int CFG_W           = 31;
	localparam int IDX_W           = 1;

	localparam logic [IDX_W-1:0] REG_FIELD_DEGREE   = 1'd0;
	localparam logic [IDX_W-1:0] REG_REDUCTION_POLY = 1'd1;

	localparam logic [4:0]  DEGREE_RESET = 5'd31;
	localparam logic [30:0] POLY_RESET   = 31'd9;

	// multiplier request from the sequencer
	typedef struct packed {
		logic start;
		logic [4:0] degree;
	} mul_ctl_t;

endpackage

/* hdl/binary_curve_point_scalar_mul.sv */
// ----------------------------------------------------------------------------
// binary_curve_point_scalar_mul
// Affine point add and right-to-left double-and-add on y^2+xy=x^3+1 over
// GF(2^n), one shared bit-serial field multiplier under a sequencer.
// ----------------------------------------------------------------------------
// channel  dir  handshake             contents
// s_axis   in   s_axis_tvalid/tready  command word
// m_axis   out  m_axis_tvalid/tready  result point word
// cfg      in   cfg_we                degree / polynomial write
//
// an inversion takes 2(n-1) multiplies and a point operation about 2n+2, so a 32-bit
// scalar with degree 31 runs up to roughly 64 point operations. reset clears
// control and config. the next word is taken only after the result word has
// left the output.
// ----------------------------------------------------------------------------
module binary_curve_point_scalar_mul #(
	parameter int FIELD_BITS  = bcpsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = bcpsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcpsm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bcpsm_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// first_x, first_y, first_inf, second_x, second_y, second_inf, scalar
	input  logic [((4*FIELD_BITS+2+SCALAR_BITS+7)/8)*8-1:0] s_axis_tdata,
	// cmd
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// result_x, result_y, result_inf
	output logic [((2*FIELD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);
	import bcpsm_pkg::*;

	localparam int F  = FIELD_BITS;
	localparam int OW = ((2*F+1+7)/8)*8;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_OP   = 10'b0000000010,
		ST_INV  = 10'b0000000100,
		ST_L1   = 10'b0000001000,
		ST_X1   = 10'b0000010000,
		ST_Y1   = 10'b0000100000,
		ST_Y2   = 10'b0001000000,
		ST_NEXT = 10'b0010000000,
		ST_MULW = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, ret_q;

	logic [4:0]   deg_q;
	logic [30:0]  poly_q;
	logic [4:0]   n;
	logic [F-1:0] m;

	// clamped degree and mask
	always_comb begin
		n = deg_q;
		if (n < 5'd3) n = 5'd3;
		if (int'(n) > F) n = 5'(F);
		for (int i = 0; i < F; i++) m[i] = (i < int'(n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= DEGREE_RESET;
			poly_q <= POLY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIELD_DEGREE:   deg_q  <= cfg_data[4:0];
				REG_REDUCTION_POLY: poly_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// point registers: p is the operand/doubled point, q the accumulator or second
	logic [F-1:0] px_q, py_q, qx_q, qy_q, rx_q, ry_q;
	logic         pinf_q, qinf_q, rinf_q;
	logic         cmd_q, dbl_q, phase_q;
	logic [SCALAR_BITS-1:0] k_q;
	logic [F-1:0] inv_r_q, inv_b_q, lam_q, t_q;
	logic [4:0]   ecnt_q;
	logic         isq_q;

	mul_ctl_t     mctl;
	logic [F-1:0] ma_q, mb_q, prod;
	logic         mdone;

	bcpsm_gf_mul #(.FIELD_BITS(F)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .poly(poly_q[F-1:0] & m),
		.a(ma_q), .b(mb_q), .prod(prod), .done(mdone)
	);

	logic mstart_q;
	assign mctl.start  = mstart_q;
	assign mctl.degree = n;

	// operand pair for the current point op: dbl uses p+p, scale add q+p, add command p+q
	logic [F-1:0] ax, ay, bx, by;
	logic         ainf, binf;
	always_comb begin
		if (!cmd_q) begin
			ax = px_q; ay = py_q; ainf = pinf_q; bx = qx_q; by = qy_q; binf = qinf_q;
		end else if (dbl_q) begin
			ax = px_q; ay = py_q; ainf = pinf_q; bx = px_q; by = py_q; binf = pinf_q;
		end else begin
			ax = qx_q; ay = qy_q; ainf = qinf_q; bx = px_q; by = py_q; binf = pinf_q;
		end
	end

	logic same;
	assign same = (ax == bx);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = OW'({rinf_q, (rinf_q ? {F{1'b0}} : ry_q),
		(rinf_q ? {F{1'b0}} : rx_q)});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			mstart_q <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					cmd_q  <= s_axis_tuser;
					px_q   <= s_axis_tdata[F-1:0] & m;
					py_q   <= s_axis_tdata[2*F-1:F] & m;
					pinf_q <= s_axis_tdata[2*F];
					qx_q   <= s_axis_tdata[3*F:2*F+1] & m;
					qy_q   <= s_axis_tdata[4*F:3*F+1] & m;
					qinf_q <= s_axis_tdata[4*F+1];
					k_q    <= s_axis_tdata[4*F+2+SCALAR_BITS-1:4*F+2];
					if (s_axis_tuser) begin
						qinf_q <= 1'b1;
						qx_q   <= '0;
						qy_q   <= '0;
					end
					dbl_q   <= 1'b0;
					state_q <= ST_OP;
				end
				ST_OP: begin
					// pick next operation; in scale mode add if bit set else double
					if (cmd_q && !dbl_q && k_q == '0) begin
						rx_q <= qx_q; ry_q <= qy_q; rinf_q <= qinf_q;
						state_q <= ST_OUT;
					end else if (cmd_q && !dbl_q && !k_q[0]) begin
						dbl_q <= 1'b1;
					end else if (ainf) begin
						rx_q <= bx; ry_q <= by; rinf_q <= binf; state_q <= ST_NEXT;
					end else if (binf) begin
						rx_q <= ax; ry_q <= ay; rinf_q <= ainf; state_q <= ST_NEXT;
					end else if (same && ((ay ^ by) == ax || ax == '0)) begin
						rx_q <= '0; ry_q <= '0; rinf_q <= 1'b1; state_q <= ST_NEXT;
					end else begin
						// inverse of x1 or x1^x2 by square-and-multiply of 2^n-2
						inv_r_q <= {{(F-1){1'b0}}, 1'b1};
						inv_b_q <= same ? ax : (ax ^ bx);
						ecnt_q  <= n - 5'd1;
						isq_q   <= 1'b1;
						state_q <= ST_INV;
					end
				end
				ST_INV: begin
					// exponent bits: bit 0 clear, bits 1..n-1 set
					if (ecnt_q == 5'd0) begin
						ma_q <= same ? ay : (ay ^ by); mb_q <= inv_r_q;
						mstart_q <= 1'b1; ret_q <= ST_L1; state_q <= ST_MULW;
					end else if (isq_q) begin
						ma_q <= inv_b_q; mb_q <= inv_b_q; mstart_q <= 1'b1;
						phase_q <= 1'b0; ret_q <= ST_INV; state_q <= ST_MULW;
					end else begin
						ma_q <= inv_r_q; mb_q <= inv_b_q; mstart_q <= 1'b1;
						phase_q <= 1'b1; ret_q <= ST_INV; state_q <= ST_MULW;
					end
				end
				ST_MULW: if (mdone) begin
					state_q <= ret_q;
					if (ret_q == ST_INV) begin
						if (!phase_q) begin
							inv_b_q <= prod; isq_q <= 1'b0;
						end else begin
							inv_r_q <= prod; isq_q <= 1'b1;
							ecnt_q <= ecnt_q - 5'd1;
						end
					end else begin
						t_q <= prod;
					end
				end
				ST_L1: begin
					lam_q <= same ? (ax ^ t_q) : t_q;
					ma_q <= same ? (ax ^ t_q) : t_q; mb_q <= same ? (ax ^ t_q) : t_q;
					mstart_q <= 1'b1; ret_q <= ST_X1; state_q <= ST_MULW;
				end
				ST_X1: begin
					rx_q <= same ? (t_q ^ lam_q) : (t_q ^ lam_q ^ ax ^ bx);
					if (same) begin
						ma_q <= ax; mb_q <= ax;
					end else begin
						ma_q <= lam_q; mb_q <= ax ^ t_q ^ lam_q ^ ax ^ bx;
					end
					mstart_q <= 1'b1; ret_q <= ST_Y1; state_q <= ST_MULW;
				end
				ST_Y1: begin
					if (same) begin
						ry_q <= t_q;
						ma_q <= lam_q ^ {{(F-1){1'b0}}, 1'b1}; mb_q <= rx_q;
						mstart_q <= 1'b1; ret_q <= ST_Y2; state_q <= ST_MULW;
					end else begin
						ry_q <= t_q ^ rx_q ^ ay; rinf_q <= 1'b0; state_q <= ST_NEXT;
					end
				end
				ST_Y2: begin
					ry_q <= ry_q ^ t_q; rinf_q <= 1'b0; state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (!cmd_q) begin
						state_q <= ST_OUT;
					end else if (dbl_q) begin
						px_q <= rx_q; py_q <= ry_q; pinf_q <= rinf_q;
						k_q <= k_q >> 1; dbl_q <= 1'b0; state_q <= ST_OP;
					end else begin
						qx_q <= rx_q; qy_q <= ry_q; qinf_q <= rinf_q;
						dbl_q <= 1'b1; state_q <= ST_OP;
					end
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/bcpsm_gf_mul.sv */
// ----------------------------------------------------------------------------
// bcpsm_gf_mul
// Bit-serial GF(2^n) multiplier: one operand bit per cycle, msb first,
// with interleaved reduction by the configured polynomial.
// ----------------------------------------------------------------------------
module bcpsm_gf_mul #(
	parameter int FIELD_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcpsm_pkg::mul_ctl_t   ctl,
	input  logic [FIELD_BITS-1:0] poly,
	input  logic [FIELD_BITS-1:0] a,
	input  logic [FIELD_BITS-1:0] b,
	output logic [FIELD_BITS-1:0] prod,
	output logic                  done
);
	import bcpsm_pkg::*;

	localparam int CW = $clog2(FIELD_BITS + 1);

	logic [FIELD_BITS-1:0] acc_q, a_q, b_q, poly_q;
	logic [CW-1:0]         cnt_q;
	logic [4:0]            deg_q;
	logic                  busy_q;
	logic [FIELD_BITS:0]   sh;
	logic [FIELD_BITS-1:0] nxt;
	logic                  top;

	// shift accumulator left by one, reduce the z^n term, add a when bit set
	always_comb begin
		sh  = {acc_q, 1'b0};
		top = sh[deg_q];
		nxt = sh[FIELD_BITS-1:0];
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (i >= int'(deg_q)) nxt[i] = 1'b0;
		end
		if (top) nxt = nxt ^ poly_q;
		if (b_q[cnt_q[CW-1:0] - 1'b1]) nxt = nxt ^ a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ctl.degree);
				deg_q  <= ctl.degree;
				acc_q  <= '0;
				a_q    <= a;
				b_q    <= b;
				poly_q <= poly;
			end else if (busy_q) begin
				acc_q <= nxt;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign prod = acc_q;

endmodule

/* bench/tb_point_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_checker
// Watches the command, result and config channels of the point multiplier,
// predicts each result point in GF(2^n) and compares it with the output word.
// ----------------------------------------------------------------------------
module tb_point_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bcpsm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [bcpsm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [159:0]                        s_axis_tdata,
	input  logic                                s_axis_tuser,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [63:0]                         m_axis_tdata,
	output int                                  pending,
	output int                                  fail_count
);
	import bcpsm_pkg::*;

	typedef struct {
		logic [63:0] x;
		logic [63:0] y;
		bit          inf;
	} point_t;

	logic [4:0]  degree_reg;
	logic [30:0] poly_reg;
	logic [62:0] point_q[$];

	// carry-less multiply, truncated to 64 bits
	function automatic logic [63:0] clmul(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 64; i++)
			if (b[i]) r ^= a << i;
		return r;
	endfunction

	function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b, int n,
			logic [63:0] poly);
		logic [63:0] m, c;
		m = (64'd1 << n) - 1;
		c = clmul(a & m, b & m);
		while ((c >> n) != 0) c = (c & m) ^ clmul(c >> n, poly & m);
		return c;
	endfunction

	// inverse as a^(2^n-2)
	function automatic logic [63:0] finv(logic [63:0] a, int n, logic [63:0] poly);
		logic [63:0] r, base, e;
		r = 1;
		base = a;
		e = (64'd1 << n) - 2;
		while (e != 0) begin
			if (e[0]) r = fmul(r, base, n, poly);
			base = fmul(base, base, n, poly);
			e >>= 1;
		end
		return r;
	endfunction

	function automatic point_t padd(point_t p, point_t q, int n, logic [63:0] poly);
		point_t r;
		logic [63:0] lam;
		r.x = 0;
		r.y = 0;
		r.inf = 1'b1;
		if (p.inf) return q;
		if (q.inf) return p;
		if (p.x == q.x) begin
			// negation pair or x = 0 both give infinity
			if ((p.y ^ q.y) == p.x || p.x == 0) return r;
			lam = p.x ^ fmul(p.y, finv(p.x, n, poly), n, poly);
			r.x = fmul(lam, lam, n, poly) ^ lam;
			r.y = fmul(p.x, p.x, n, poly) ^ fmul(lam ^ 1, r.x, n, poly);
			r.inf = 1'b0;
			return r;
		end
		lam = fmul(p.y ^ q.y, finv(p.x ^ q.x, n, poly), n, poly);
		r.x = fmul(lam, lam, n, poly) ^ lam ^ p.x ^ q.x;
		r.y = fmul(lam, p.x ^ r.x, n, poly) ^ r.x ^ p.y;
		r.inf = 1'b0;
		return r;
	endfunction

	function automatic point_t to_point(logic [30:0] x, logic [30:0] y, bit inf, int n);
		point_t r;
		logic [63:0] m;
		m = (64'd1 << n) - 1;
		r.x = inf ? 0 : x & m;
		r.y = inf ? 0 : y & m;
		r.inf = inf;
		return r;
	endfunction

	// expected output word for one command word
	function automatic logic [62:0] predict_point(logic [159:0] d, logic cmd);
		int n;
		logic [63:0] poly;
		logic [31:0] k;
		point_t p, q, acc;
		n = (degree_reg < 3) ? 3 : int'(degree_reg);
		poly = {33'd0, poly_reg};
		p = to_point(d[30:0], d[61:31], d[62], n);
		if (cmd) begin
			k = d[157:126];
			acc.x = 0;
			acc.y = 0;
			acc.inf = 1'b1;
			while (k != 0) begin
				if (k[0]) acc = padd(acc, p, n, poly);
				p = padd(p, p, n, poly);
				k >>= 1;
			end
		end else begin
			q = to_point(d[93:63], d[124:94], d[125], n);
			acc = padd(p, q, n, poly);
		end
		if (acc.inf) return {1'b1, 62'd0};
		return {1'b0, acc.y[30:0], acc.x[30:0]};
	endfunction

	// config mirror
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_reg <= DEGREE_RESET;
			poly_reg <= POLY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_FIELD_DEGREE) degree_reg <= cfg_data[4:0];
			else if (cfg_index == REG_REDUCTION_POLY) poly_reg <= cfg_data[30:0];
		end
	end

	// predict on accepted command words, compare accepted result words
	always @(posedge clk) begin
		logic [62:0] exp_w;
		if (!arst_n) begin
			point_q.delete();
			fail_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				point_q.push_back(predict_point(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				if (point_q.size() == 0) begin
					$error("unexpected result word %h", m_axis_tdata);
					fail_count++;
				end else begin
					exp_w = point_q.pop_front();
					if (m_axis_tdata[30:0] !== exp_w[30:0]) begin
						$error("result_x expected %h got %h", exp_w[30:0],
							m_axis_tdata[30:0]);
						fail_count++;
					end
					if (m_axis_tdata[61:31] !== exp_w[61:31]) begin
						$error("result_y expected %h got %h", exp_w[61:31],
							m_axis_tdata[61:31]);
						fail_count++;
					end
					if (m_axis_tdata[62] !== exp_w[62]) begin
						$error("result_inf expected %b got %b", exp_w[62],
							m_axis_tdata[62]);
						fail_count++;
					end
				end
			end
		end
		pending = point_q.size();
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the binary curve point multiplier: directed special points,
// then random adds and scalar multiplies over several field settings.
// ----------------------------------------------------------------------------
module tb_top;
	import bcpsm_pkg::*;

	localparam int IDLE_LIMIT = 1000000;
	localparam int LONG_HOLD  = 40000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// first_x, first_y, first_inf, second_x, second_y, second_inf, scalar
	logic [159:0] s_axis_tdata;
	// cmd
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// result_x, result_y, result_inf
	logic [63:0]  m_axis_tdata;

	int  pending;
	int  fail_count;
	int  idle_cycles = 0;
	int  cur_degree;
	int  add_count;
	int  mul_count;
	int  phase_count;
	bit  no_idle;
	bit  hold_rx;

	binary_curve_point_scalar_mul dut (.*);

	tb_point_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx && !held) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				held = 1'b1;
			end
			gap = no_idle ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_word(bit cmd, logic [30:0] x1, logic [30:0] y1, bit inf1,
			logic [30:0] x2, logic [30:0] y2, bit inf2, logic [31:0] k);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {2'b00, k, inf2, y2, x2, inf1, y1, x1};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (cmd) mul_count++;
		else add_count++;
	endtask

	// block is idle once every result is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_field(int deg, logic [30:0] poly);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIELD_DEGREE;
		cfg_data <= {26'($urandom_range(0, 32'h3ffffff)), deg[4:0]};
		@(posedge clk);
		cfg_index <= REG_REDUCTION_POLY;
		cfg_data <= poly;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_degree = (deg < 3) ? 3 : deg;
		phase_count++;
	endtask

	// random item: random points, some with special relations between the two
	task automatic send_random();
		logic [30:0] x1, y1, x2, y2;
		logic [31:0] k;
		bit cmd, inf1, inf2;
		int kind;
		x1 = 31'($urandom);
		y1 = 31'($urandom);
		x2 = 31'($urandom);
		y2 = 31'($urandom);
		inf1 = ($urandom_range(0, 9) == 0);
		inf2 = ($urandom_range(0, 9) == 0);
		cmd = 1'($urandom_range(0, 1));
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				x2 = x1;
				y2 = y1 ^ x1;
			end
			1, 2: begin
				x2 = x1;
				y2 = y1;
			end
			3: begin
				x1 = '0;
				x2 = '0;
			end
			default: ;
		endcase
		if (cur_degree > 13) k = $urandom_range(0, 255);
		else if ($urandom_range(0, 2) == 0) k = $urandom_range(0, 15);
		else k = $urandom;
		send_word(cmd, x1, y1, inf1, x2, y2, inf2, k);
	endtask

	initial begin
		int deg_list[7];
		logic [30:0] poly_list[7];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		add_count = 0;
		mul_count = 0;
		phase_count = 0;
		cur_degree = 31;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset field z^31 + z^3 + 1
		send_word(1'b0, '0, '0, 1'b1, 31'h1234567, 31'h7654321, 1'b0, '0);
		send_word(1'b0, 31'h7fffffff, 31'h7fffffff, 1'b0, '0, '0, 1'b1, '0);
		send_word(1'b0, 31'h5a5a5a5, 31'h1, 1'b1, 31'h3, 31'h4, 1'b1, '0);
		send_word(1'b0, 31'h2345, 31'h6789, 1'b0, 31'h2345, 31'h6789 ^ 31'h2345, 1'b0,
			'0);
		send_word(1'b0, '0, 31'h11, 1'b0, '0, 31'h22, 1'b0, '0);
		send_word(1'b0, '0, 31'h11, 1'b0, '0, 31'h11, 1'b0, '0);
		send_word(1'b0, 31'h2345, 31'h6789, 1'b0, 31'h2345, 31'h6789, 1'b0, '0);
		send_word(1'b0, 31'h7fffffff, 31'h0, 1'b0, 31'h1, 31'h7fffffff, 1'b0, '0);
		send_word(1'b1, 31'h2345, 31'h6789, 1'b0, '0, '0, 1'b0, 32'd0);
		send_word(1'b1, 31'h2345, 31'h6789, 1'b0, '0, '0, 1'b0, 32'd1);
		send_word(1'b1, 31'h2345, 31'h6789, 1'b0, '0, '0, 1'b0, 32'd2);
		send_word(1'b1, 31'h2345, 31'h6789, 1'b1, '0, '0, 1'b0, 32'd77);
		send_word(1'b1, '0, 31'h1, 1'b0, '0, '0, 1'b0, 32'd5);
		send_word(1'b1, 31'h7fffffff, 31'h7fffffff, 1'b0, '0, '0, 1'b0, 32'hffffffff);
		wait_drained();

		// the extremes: full-width tail, then the smallest field
		write_field(31, 31'h7fffffff);
		send_word(1'b0, 31'h1, 31'h7fffffff, 1'b0, 31'h7ffffffe, 31'h2, 1'b0, '0);
		send_word(1'b1, 31'h3, 31'h5, 1'b0, '0, '0, 1'b0, 32'd13);
		wait_drained();
		write_field(3, 31'h1);
		send_word(1'b1, 31'h7fffffff, 31'h7fffffff, 1'b0, '0, '0, 1'b0, 32'hffffffff);
		send_word(1'b0, 31'h5, 31'h6, 1'b0, 31'h2, 31'h7, 1'b0, '0);
		wait_drained();

		// random phases over several fields
		deg_list = '{5, 7, 2, 13, 11, 0, 31};
		poly_list = '{31'h5, 31'h3, 31'h3, 31'h1b, 31'h5, 31'h0, 31'h9};
		poly_list[5] = 31'($urandom);
		for (int ph = 0; ph < 7; ph++) begin
			write_field(deg_list[ph], poly_list[ph]);
			no_idle = (ph == 3);
			if (ph == 1) hold_rx = 1;
			for (int i = 0; i < ((ph == 6) ? 8 : 17); i++) send_random();
			wait_drained();
		end
		no_idle = 0;

		// random field and tail, small degree
		write_field($urandom_range(3, 9), 31'($urandom));
		for (int i = 0; i < 10; i++) send_random();
		wait_drained();
		repeat (100) @(posedge clk);

		$display("covered %0d adds and %0d scalar multiplies over %0d field settings",
			add_count, mul_count, phase_count);
		$display("special points: identity, negation pair, x = 0, doubling, long output stall");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
